>>> src/bop_pkg.sv
// ----------------------------------------------------------------------------
// Branch outcome predictor package
// Prediction modes, table constants and the decision record shared by the
// decision logic and the top level.
// ----------------------------------------------------------------------------
package bop_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 1024;

  localparam int unsigned PC_W  = 64;
  localparam int unsigned OFF_W = 13;
  localparam int unsigned CTR_W = 2;
  localparam int unsigned CNT_W = 32;

  localparam logic [1:0] MODE_ALWAYS_TAKEN = 2'd0;
  localparam logic [1:0] MODE_ALWAYS_NOT   = 2'd1;
  localparam logic [1:0] MODE_ONE_BIT      = 2'd2;
  localparam logic [1:0] MODE_TWO_BIT      = 2'd3;

  localparam logic [CTR_W-1:0] CTR_MAX     = 2'd3;
  localparam logic [CTR_W-1:0] CTR_MIN     = 2'd0;
  localparam logic [CTR_W-1:0] CTR_WEAK_NT = 2'd1;
  localparam logic [PC_W-1:0]  PC_STEP     = 64'd4;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic             pred;
    logic             actual;
    logic             right;
    logic             tbl_we;
    logic [CTR_W-1:0] ctr_n;
    logic [PC_W-1:0]  target;
  } bop_dec_t;

endpackage

>>> src/bop_decide.sv
// ----------------------------------------------------------------------------
// Branch outcome predictor decision logic
// Forms the prediction, the outcome, the new counter and the target for one
// resolved branch from its table entry as looked up.
// ----------------------------------------------------------------------------
module bop_decide (
  input  logic [1:0]                  mode_i,
  input  logic [bop_pkg::PC_W-1:0]    pc_i,
  input  logic [bop_pkg::PC_W-1:0]    npc_i,
  input  logic signed [bop_pkg::OFF_W-1:0] off_i,
  input  logic                        hit_i,
  input  logic [bop_pkg::CTR_W-1:0]   ctr_i,
  output bop_pkg::bop_dec_t           dec_o
);
  import bop_pkg::*;

  logic [PC_W-1:0]  seq_pc;
  logic [PC_W-1:0]  taken_pc;
  logic             actual;
  logic             dyn_pred;
  logic [CTR_W-1:0] two_ctr;

  assign seq_pc   = pc_i + PC_STEP;
  assign taken_pc = pc_i + {{(PC_W-OFF_W){off_i[OFF_W-1]}}, off_i};
  assign actual   = (npc_i - pc_i) != PC_STEP;
  assign dyn_pred = hit_i & ctr_i[CTR_W-1];

  // A first encounter starts the counter at weakly not-taken if taken, else at zero.
  always_comb begin
    priority if (!hit_i) begin
      two_ctr = actual ? CTR_WEAK_NT : CTR_MIN;
    end else if (actual) begin
      two_ctr = (ctr_i == CTR_MAX) ? CTR_MAX : ctr_i + CTR_W'(1);
    end else begin
      two_ctr = (ctr_i == CTR_MIN) ? CTR_MIN : ctr_i - CTR_W'(1);
    end
  end

  always_comb begin
    dec_o        = '0;
    dec_o.actual = actual;
    unique case (mode_i)
      MODE_ALWAYS_TAKEN: begin
        dec_o.pred   = 1'b1;
        dec_o.target = taken_pc;
      end
      MODE_ALWAYS_NOT: begin
        dec_o.pred   = 1'b0;
        dec_o.target = seq_pc;
      end
      MODE_ONE_BIT: begin
        dec_o.pred   = dyn_pred;
        dec_o.tbl_we = 1'b1;
        dec_o.ctr_n  = actual ? CTR_MAX : CTR_MIN;
        dec_o.target = npc_i;
      end
      default: begin
        dec_o.pred   = dyn_pred;
        dec_o.tbl_we = 1'b1;
        dec_o.ctr_n  = two_ctr;
        dec_o.target = two_ctr[CTR_W-1] ? taken_pc : seq_pc;
      end
    endcase
    dec_o.right = (dec_o.pred == actual);
  end

endmodule

>>> src/branch_outcome_predictor.sv
// ----------------------------------------------------------------------------
// Branch outcome predictor
// Bimodal predictor with a direct-mapped tagged counter table, static modes
// and saturating statistics counts.
// ----------------------------------------------------------------------------
//   channel  | handshake                | payload
//   ---------+--------------------------+-----------------------------------
//   input    | in_valid_i / in_stall_o  | branch_pc_i, next_pc_i,
//            |                          | branch_offset_i
//   output   | out_valid_o / out_stall_i| predicted_taken_o, actual_taken_o,
//            |                          | prediction_right_o, buffer_target_o,
//            |                          | right_count_o, branch_count_o
//   config   | cfg_we_i                 | cfg_data_i (predict mode)
//
// One item per cycle is sustained after clearing while the output is not
// stalled. An accepted item sits in the lookup stage while the table's single
// read port returns its entry, and its result is loaded into the output
// register when that stage advances. The last table write is forwarded to
// the lookup. After reset a clearing pass walks every table entry and no
// item is taken during it. A stall at the output holds the output register,
// then the item in the lookup stage, and stalls the input only when both
// stages are full.
// TABLE_ENTRIES must be a power of two; the index is the low pc bits above
// bit zero.
module branch_outcome_predictor #(
  parameter int unsigned TABLE_ENTRIES = bop_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [bop_pkg::PC_W-1:0]          branch_pc_i,
  input  logic [bop_pkg::PC_W-1:0]          next_pc_i,
  input  logic signed [bop_pkg::OFF_W-1:0]  branch_offset_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              predicted_taken_o,
  output logic                              actual_taken_o,
  output logic                              prediction_right_o,
  output logic [bop_pkg::PC_W-1:0]          buffer_target_o,
  output logic [bop_pkg::CNT_W-1:0]         right_count_o,
  output logic [bop_pkg::CNT_W-1:0]         branch_count_o
);
  import bop_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned TAG_W = PC_W - 1 - IDX_W;
  localparam int unsigned ENT_W = 1 + TAG_W + CTR_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  // Entry layout: valid, tag, counter.
  logic [ENT_W-1:0] tbl_mem [TABLE_ENTRIES];

  logic [1:0]       mode_q;
  logic             clr_busy_q;
  logic [IDX_W-1:0] clr_idx_q;

  logic                   s1_vld_q;
  logic [PC_W-1:0]        s1_pc_q;
  logic [PC_W-1:0]        s1_npc_q;
  logic signed [OFF_W-1:0] s1_off_q;
  logic [ENT_W-1:0]       rd_q;

  logic             fwd_vld_q;
  logic [IDX_W-1:0] fwd_idx_q;
  logic [ENT_W-1:0] fwd_ent_q;

  logic [CNT_W-1:0] right_q, right_d;
  logic [CNT_W-1:0] seen_q, seen_d;

  logic             out_vld_q;
  logic             out_pred_q;
  logic             out_act_q;
  logic             out_right_q;
  logic [PC_W-1:0]  out_tgt_q;
  logic [CNT_W-1:0] out_rcnt_q;
  logic [CNT_W-1:0] out_bcnt_q;

  logic             in_accept;
  logic             s1_adv;
  logic [IDX_W-1:0] in_idx;
  logic [IDX_W-1:0] s1_idx;
  logic [TAG_W-1:0] s1_tag;
  logic [ENT_W-1:0] cur_ent;
  logic             hit;
  bop_dec_t         dec;
  logic             upd_we;
  logic [ENT_W-1:0] upd_ent;
  logic             mem_we;
  logic [IDX_W-1:0] mem_widx;
  logic [ENT_W-1:0] mem_wdata;

  assign s1_adv     = s1_vld_q & (~out_vld_q | ~out_stall_i);
  assign in_stall_o = clr_busy_q | (s1_vld_q & ~s1_adv);
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign in_idx = branch_pc_i[IDX_W:1];
  assign s1_idx = s1_pc_q[IDX_W:1];
  assign s1_tag = s1_pc_q[PC_W-1:IDX_W+1];

  // The entry written by the previous item can land in the table at the same
  // edge at which this item's read is taken, so it is forwarded here.
  assign cur_ent = (fwd_vld_q && fwd_idx_q == s1_idx) ? fwd_ent_q : rd_q;
  assign hit     = cur_ent[ENT_W-1] && (cur_ent[ENT_W-2:CTR_W] == s1_tag);

  bop_decide u_decide (
    .mode_i (mode_q),
    .pc_i   (s1_pc_q),
    .npc_i  (s1_npc_q),
    .off_i  (s1_off_q),
    .hit_i  (hit),
    .ctr_i  (cur_ent[CTR_W-1:0]),
    .dec_o  (dec)
  );

  assign upd_we  = s1_adv & dec.tbl_we;
  assign upd_ent = {1'b1, s1_tag, dec.ctr_n};

  assign mem_we    = clr_busy_q | upd_we;
  assign mem_widx  = clr_busy_q ? clr_idx_q : s1_idx;
  assign mem_wdata = clr_busy_q ? '0 : upd_ent;

  assign right_d = (dec.right && right_q != CNT_MAX) ? right_q + CNT_W'(1) : right_q;
  assign seen_d  = (seen_q != CNT_MAX) ? seen_q + CNT_W'(1) : seen_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rd_q <= tbl_mem[in_idx];
    end
    if (mem_we) begin
      tbl_mem[mem_widx] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_TWO_BIT;
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
      s1_vld_q   <= 1'b0;
      fwd_vld_q  <= 1'b0;
      right_q    <= '0;
      seen_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_data_i;
      end
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + IDX_W'(1);
        if (clr_idx_q == IDX_LAST) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (in_accept) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (upd_we) begin
        fwd_vld_q <= 1'b1;
      end
      if (s1_adv) begin
        right_q   <= right_d;
        seen_q    <= seen_d;
        out_vld_q <= 1'b1;
      end else if (~out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pc_q  <= branch_pc_i;
      s1_npc_q <= next_pc_i;
      s1_off_q <= branch_offset_i;
    end
    if (upd_we) begin
      fwd_idx_q <= s1_idx;
      fwd_ent_q <= upd_ent;
    end
    if (s1_adv) begin
      out_pred_q  <= dec.pred;
      out_act_q   <= dec.actual;
      out_right_q <= dec.right;
      out_tgt_q   <= dec.target;
      out_rcnt_q  <= right_d;
      out_bcnt_q  <= seen_d;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign predicted_taken_o  = out_pred_q;
  assign actual_taken_o     = out_act_q;
  assign prediction_right_o = out_right_q;
  assign buffer_target_o    = out_tgt_q;
  assign right_count_o      = out_rcnt_q;
  assign branch_count_o     = out_bcnt_q;

  a_clear_blocks_items: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s1_vld_q && !in_accept)
    else $error("item in flight during table clearing");

  a_adv_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_vld_q)
    else $error("advanced item did not reach the output register");

  a_counts_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_rcnt_q <= out_bcnt_q)
    else $error("right count exceeds branch count");

  a_seen_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && seen_q != CNT_MAX |=> seen_q == $past(seen_q) + CNT_W'(1))
    else $error("branch count did not advance");

  a_static_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_ALWAYS_TAKEN || mode_q == MODE_ALWAYS_NOT) |-> !upd_we)
    else $error("table written in a static mode");

endmodule
